// ----- hdl/mcc_pkg.sv -----
// ----------------------------------------------------------------------------
// mcc_pkg
// shared types, code table and lookups for the morse code converter
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

  localparam int NUM_CODES   = 40;
  localparam int MAX_SYMBOLS = 6;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_FOLD  = 8'h20;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // apb register map
  localparam int          ADDR_W       = 3;
  localparam logic        REG_DIRECTION = 1'b0;

  // one entry of the code table: bit i of bits is symbol i, 1 = dash
  typedef struct packed {
    logic [7:0] ch;
    logic [5:0] bits;
    logic [2:0] len;
  } code_entry_t;

  // decode state carried from item to item
  typedef struct packed {
    logic [5:0] code_bits;
    logic [2:0] code_length;
    logic       code_overflow;
    logic       prev_was_space;
  } dec_state_t;

  // result burst of one item: len symbols from bits, then the tail byte
  typedef struct packed {
    logic       emit;
    logic [5:0] bits;
    logic [2:0] len;
    logic [7:0] tail;
  } burst_t;

  typedef struct packed {
    logic       found;
    logic [5:0] bits;
    logic [2:0] len;
  } enc_hit_t;

  typedef struct packed {
    logic       found;
    logic [7:0] ch;
  } dec_hit_t;

  localparam code_entry_t CODE_TABLE [NUM_CODES] = '{
    '{8'h41, 6'b000010, 3'd2}, // A
    '{8'h42, 6'b000001, 3'd4}, // B
    '{8'h43, 6'b000101, 3'd4}, // C
    '{8'h44, 6'b000001, 3'd3}, // D
    '{8'h45, 6'b000000, 3'd1}, // E
    '{8'h46, 6'b000100, 3'd4}, // F
    '{8'h47, 6'b000011, 3'd3}, // G
    '{8'h48, 6'b000000, 3'd4}, // H
    '{8'h49, 6'b000000, 3'd2}, // I
    '{8'h4A, 6'b001110, 3'd4}, // J
    '{8'h4B, 6'b000101, 3'd3}, // K
    '{8'h4C, 6'b000010, 3'd4}, // L
    '{8'h4D, 6'b000011, 3'd2}, // M
    '{8'h4E, 6'b000001, 3'd2}, // N
    '{8'h4F, 6'b000111, 3'd3}, // O
    '{8'h50, 6'b000110, 3'd4}, // P
    '{8'h51, 6'b001011, 3'd4}, // Q
    '{8'h52, 6'b000010, 3'd3}, // R
    '{8'h53, 6'b000000, 3'd3}, // S
    '{8'h54, 6'b000001, 3'd1}, // T
    '{8'h55, 6'b000100, 3'd3}, // U
    '{8'h56, 6'b001000, 3'd4}, // V
    '{8'h57, 6'b000110, 3'd3}, // W
    '{8'h58, 6'b001001, 3'd4}, // X
    '{8'h59, 6'b001101, 3'd4}, // Y
    '{8'h5A, 6'b000011, 3'd4}, // Z
    '{8'h30, 6'b011111, 3'd5}, // 0
    '{8'h31, 6'b011110, 3'd5}, // 1
    '{8'h32, 6'b011100, 3'd5}, // 2
    '{8'h33, 6'b011000, 3'd5}, // 3
    '{8'h34, 6'b010000, 3'd5}, // 4
    '{8'h35, 6'b000000, 3'd5}, // 5
    '{8'h36, 6'b000001, 3'd5}, // 6
    '{8'h37, 6'b000011, 3'd5}, // 7
    '{8'h38, 6'b000111, 3'd5}, // 8
    '{8'h39, 6'b001111, 3'd5}, // 9
    '{8'h2E, 6'b101010, 3'd6}, // period
    '{8'h2C, 6'b110011, 3'd6}, // comma
    '{8'h3F, 6'b001100, 3'd6}, // question mark
    '{8'h22, 6'b010010, 3'd6}  // double quote
  };

  // character to code
  function automatic enc_hit_t enc_lookup(input logic [7:0] ch);
    enc_hit_t hit;
    hit = '0;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (!hit.found && CODE_TABLE[i].ch == ch) begin
        hit.found = 1'b1;
        hit.bits  = CODE_TABLE[i].bits;
        hit.len   = CODE_TABLE[i].len;
      end
    end
    return hit;
  endfunction

  // code to character
  function automatic dec_hit_t dec_lookup(input logic [5:0] bits, input logic [2:0] len);
    dec_hit_t hit;
    hit = '0;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (!hit.found && CODE_TABLE[i].bits == bits && CODE_TABLE[i].len == len) begin
        hit.found = 1'b1;
        hit.ch    = CODE_TABLE[i].ch;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mcc_xlate.sv -----
// ----------------------------------------------------------------------------
// mcc_xlate
// translates one input byte into a result burst and the next decode state
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_xlate (
  input  wire logic                direction,
  input  wire logic [7:0]          in_char,
  input  wire logic                end_of_text,
  input  wire mcc_pkg::dec_state_t state,
  output mcc_pkg::dec_state_t      state_next,
  output mcc_pkg::burst_t          burst
);
  import mcc_pkg::*;

  logic [7:0] folded;
  enc_hit_t   enc_hit;
  dec_state_t mid;
  logic       pending;
  logic       close_now;
  dec_hit_t   dec_hit;

  // encode side
  always_comb begin
    folded = in_char;
    if (in_char >= CHAR_LOW_A && in_char <= CHAR_LOW_Z) begin
      folded = in_char - CASE_FOLD;
    end
    enc_hit = enc_lookup(folded);
  end

  // decode side: apply the symbol, then close on space or end of text
  assign pending = (state.code_length != 3'd0) || state.code_overflow;
  assign dec_hit = dec_lookup(mid.code_bits, mid.code_length);

  always_comb begin
    mid       = state;
    close_now = 1'b0;
    if (in_char == CHAR_DOT || in_char == CHAR_DASH) begin
      if (state.code_length < 3'(MAX_SYMBOLS)) begin
        if (in_char == CHAR_DASH) begin
          mid.code_bits = state.code_bits | (6'd1 << state.code_length);
        end
        mid.code_length = state.code_length + 3'd1;
      end else begin
        mid.code_overflow = 1'b1;
      end
      mid.prev_was_space = 1'b0;
    end else if (in_char == CHAR_SPACE) begin
      if (pending) begin
        close_now = 1'b1;
      end
    end else begin
      mid.code_overflow  = 1'b1;
      mid.prev_was_space = 1'b0;
    end
    if (end_of_text && (mid.code_length != 3'd0 || mid.code_overflow)) begin
      close_now = 1'b1;
    end
  end

  always_comb begin
    burst      = '0;
    state_next = state;
    if (direction == DIR_ENCODE) begin
      if (folded == CHAR_SPACE) begin
        burst.emit = 1'b1;
        burst.tail = CHAR_SPACE;
      end else if (enc_hit.found) begin
        burst.emit = 1'b1;
        burst.bits = enc_hit.bits;
        burst.len  = enc_hit.len;
        burst.tail = CHAR_SPACE;
      end
    end else begin
      state_next = mid;
      if (close_now) begin
        // one lookup serves both a closing space and an end-of-text flush
        if (!mid.code_overflow && mid.code_length != 3'd0 && dec_hit.found) begin
          burst.emit = 1'b1;
          burst.tail = dec_hit.ch;
        end
        state_next.code_bits     = '0;
        state_next.code_length   = '0;
        state_next.code_overflow = 1'b0;
        state_next.prev_was_space = 1'b1;
      end else if (in_char == CHAR_SPACE) begin
        // space with no code pending: every second one is a word gap
        if (state.prev_was_space) begin
          burst.emit = 1'b1;
          burst.tail = CHAR_SPACE;
          state_next.prev_was_space = 1'b0;
        end else begin
          state_next.prev_was_space = 1'b1;
        end
      end
      if (end_of_text) begin
        state_next = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/morse_code_converter_top.sv -----
// ----------------------------------------------------------------------------
// morse_code_converter_top
// ascii text to international morse and back, one input byte per request
// ----------------------------------------------------------------------------
// the accepted item's burst is held in the burst stage and moved byte by byte
// into the output register; an item gives len+1 result bytes (up to 7 for a
//   6-symbol character, 1 for decode), one byte per cycle unless the output stalls
// items that produce nothing leave the output untouched
// reset: synchronous, clears direction, decode state and both stages
// ----------------------------------------------------------------------------
`default_nettype none

module morse_code_converter_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // apb configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mcc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  // input stream
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,   // [7:0] in_char
  input  wire logic                       s_axis_tlast,   // end_of_text
  // result stream
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [7:0]                 m_axis_tdata,   // [7:0] out_char
  output logic                            m_axis_tlast    // last
);
  import mcc_pkg::*;

  // configuration
  logic       direction;
  logic       reg_hit;

  // decode state
  dec_state_t dec_state;
  dec_state_t dec_state_next;

  // burst stage: holds the result burst of the accepted item
  burst_t     new_burst;
  logic       b_valid;
  logic [5:0] b_bits;
  logic [2:0] b_len;
  logic [7:0] b_tail;
  logic [5:0] b_shifted;
  logic [2:0] b_idx;
  logic       b_last;
  logic [7:0] b_char;

  // handshake terms
  logic       in_fire;
  logic       out_load;
  logic       b_done;

  // ---------------------------------------------------------------------------
  // apb: always ready, register selected by the word address
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1] == REG_DIRECTION);
  assign prdata  = reg_hit ? {31'd0, direction} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      direction <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // translation of one input byte
  // ---------------------------------------------------------------------------
  mcc_xlate u_xlate (
    .direction   (direction),
    .in_char     (s_axis_tdata),
    .end_of_text (s_axis_tlast),
    .state       (dec_state),
    .state_next  (dec_state_next),
    .burst       (new_burst)
  );

  // ---------------------------------------------------------------------------
  // serializer: symbols first, tail byte closes the burst
  // ---------------------------------------------------------------------------
  assign b_shifted = b_bits >> b_idx;
  assign b_last    = (b_idx == b_len);
  assign b_char    = b_last ? b_tail : (b_shifted[0] ? CHAR_DASH : CHAR_DOT);

  // the output register takes a byte whenever it is free or being drained
  assign out_load  = b_valid && (!m_axis_tvalid || m_axis_tready);
  assign b_done    = out_load && b_last;

  // next request is taken as soon as the current burst hands over its last byte
  assign s_axis_tready = !b_valid || b_done;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_state <= '0;
      b_valid   <= 1'b0;
      b_idx     <= '0;
    end else begin
      if (in_fire) begin
        dec_state <= dec_state_next;
      end
      if (in_fire && new_burst.emit) begin
        b_valid <= 1'b1;
        b_idx   <= '0;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end else if (out_load) begin
        b_idx   <= b_idx + 3'd1;
      end
    end
  end

  // burst payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && new_burst.emit) begin
      b_bits <= new_burst.bits;
      b_len  <= new_burst.len;
      b_tail <= new_burst.tail;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= b_char;
      m_axis_tlast <= b_last;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // input stalls only while a burst is still being serialized
  a_stall_has_burst: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> b_valid)
    else $error("input stalled with no burst pending");

  // serializer index never runs past the tail byte
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_idx <= b_len))
    else $error("burst index beyond tail");

  // pending code never grows past six symbols
  a_code_len: assert property (@(posedge clk) disable iff (rst)
    dec_state.code_length <= 3'(MAX_SYMBOLS))
    else $error("code length overflow");

  // encode requests leave the decode state alone
  a_enc_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (in_fire && direction == DIR_ENCODE) |=> $stable(dec_state))
    else $error("encode request changed decode state");

  // a burst's last byte is followed by a new burst or an empty stage
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (b_done && !in_fire) |=> !b_valid)
    else $error("burst stage not released after last byte");

endmodule

`default_nettype wire

// ----- tb/sv/morse_code_converter_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_code_converter_top_test
// self-checking bench for the text/morse converter: requests go in over the
// input stream, every result byte is compared against a behavioral converter
// kept in the bench, direction is switched over the apb port between phases
// ----------------------------------------------------------------------------

module morse_code_converter_top_test;

  import mcc_pkg::*;

  localparam int          CYCLE_LIMIT    = 300000;
  localparam int          RANDOM_ITEMS   = 210;
  localparam int          MAX_REPORTS    = 10;
  localparam int          SETTLE_CYCLES  = 12;
  localparam logic [2:0]  ADDR_DIRECTION = 3'd0;  // register 0, byte address 0
  localparam logic [2:0]  ADDR_UNUSED    = 3'd4;  // no register behind it
  localparam int          MORSE_COUNT    = 40;

  // one result byte as the bench expects it
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } morse_out_t;

  // character set of the converter, symbols spelled out
  logic [7:0] morse_char [MORSE_COUNT] = '{
    "A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L", "M",
    "N", "O", "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z",
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9", ".", ",", "?", "\""
  };
  string morse_code [MORSE_COUNT] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----.", ".-.-.-", "--..--", "..--..", ".-..-."
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_char
  logic        s_axis_tlast;   // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_char
  logic        m_axis_tlast;   // last

  // bench copy of the converter state
  logic        dir_model;
  logic [5:0]  dec_bits;
  logic [2:0]  dec_len;
  logic        dec_spoiled;
  logic        space_armed;

  morse_out_t  pending_bytes [$];  // result bytes still owed by the block

  int          items_sent;
  int          encode_items;
  int          decode_items;
  int          bytes_checked;
  int          mismatch_count;
  int          cycle_count;
  int          stall_left;
  bit          no_idle;            // both sides run flat out when set

  morse_code_converter_top u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // index of the table entry whose symbols match the pending code, -1 if none
  function automatic int match_code(input logic [5:0] bits, input logic [2:0] len);
    logic [5:0] b;
    int         idx;
    idx = -1;
    for (int i = 0; i < MORSE_COUNT; i++) begin
      b = '0;
      for (int k = 0; k < morse_code[i].len(); k++)
        if (morse_code[i][k] == CHAR_DASH) b[k] = 1'b1;
      if (idx < 0 && morse_code[i].len() == int'(len) && b == bits) idx = i;
    end
    return idx;
  endfunction

  // works out the bytes one accepted request must produce and queues them
  task automatic convert_request(input logic [7:0] in_char, input logic eot);
    logic [7:0] burst [$];
    logic [7:0] c;
    logic       pending;
    logic       close_now;
    int         idx;
    morse_out_t item;
    close_now = 1'b0;
    if (dir_model == DIR_ENCODE) begin
      // fold lower case, then spell the symbols and a letter gap
      c = in_char;
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) c = c - CASE_FOLD;
      if (c == CHAR_SPACE) begin
        burst.push_back(CHAR_SPACE);
      end else begin
        idx = -1;
        for (int i = 0; i < MORSE_COUNT; i++)
          if (idx < 0 && morse_char[i] == c) idx = i;
        if (idx >= 0) begin
          for (int k = 0; k < morse_code[idx].len(); k++)
            burst.push_back(morse_code[idx][k]);
          burst.push_back(CHAR_SPACE);
        end
      end
    end else begin
      pending = (dec_len != 0) || dec_spoiled;
      if (in_char == CHAR_DOT || in_char == CHAR_DASH) begin
        if (dec_len < MAX_SYMBOLS) begin
          if (in_char == CHAR_DASH) dec_bits[dec_len] = 1'b1;
          dec_len = dec_len + 3'd1;
        end else begin
          dec_spoiled = 1'b1;   // seventh symbol ruins the code
        end
        space_armed = 1'b0;
      end else if (in_char == CHAR_SPACE) begin
        if (pending) begin
          close_now   = 1'b1;
          space_armed = 1'b1;
        end else if (space_armed) begin
          burst.push_back(CHAR_SPACE);   // word gap
          space_armed = 1'b0;
        end else begin
          space_armed = 1'b1;
        end
      end else begin
        dec_spoiled = 1'b1;
        space_armed = 1'b0;
      end
      if (eot && (dec_len != 0 || dec_spoiled)) close_now = 1'b1;
      // at most one closing per request, so one place handles it
      if (close_now && !dec_spoiled && dec_len != 0) begin
        idx = match_code(dec_bits, dec_len);
        if (idx >= 0) burst.push_back(morse_char[idx]);
      end
      if (close_now || eot) begin
        dec_bits    = '0;
        dec_len     = '0;
        dec_spoiled = 1'b0;
      end
      if (eot) space_armed = 1'b0;
    end
    foreach (burst[k]) begin
      item.ch   = burst[k];
      item.last = (k == burst.size() - 1);
      pending_bytes.push_back(item);
    end
  endtask

  // one input request: optional gap, then hold until the block takes it
  task automatic send_byte(input logic [7:0] in_char, input logic eot);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= in_char;
    s_axis_tlast  <= eot;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    convert_request(in_char, eot);
    items_sent++;
    if (dir_model == DIR_ENCODE) encode_items++;
    else decode_items++;
  endtask

  // drain: stop requests, wait for every owed byte, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_DIRECTION) dir_model = data[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // read direction back and compare
  task automatic apb_check_direction();
    logic [31:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_DIRECTION;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {31'b0, dir_model}) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("direction readback: expected %h, got %h", {31'b0, dir_model}, got);
    end
  endtask

  // direction write with junk in the upper bits, which must be dropped
  task automatic set_direction(input logic dir);
    wait_idle();
    apb_write(ADDR_DIRECTION, ($urandom & 32'hFFFF_FFFE) | {31'b0, dir});
    apb_check_direction();
  endtask

  task automatic send_text(input string s, input logic eot_on_last);
    for (int k = 0; k < s.len(); k++)
      send_byte(s[k], eot_on_last && (k == s.len() - 1));
  endtask

  // ---------------------------------------------------------------- tests

  // text to morse: case folding, digits, marks, word gap, unknown bytes
  task automatic test_encode_directed();
    set_direction(DIR_ENCODE);
    send_text("Az9", 1'b0);
    send_byte("\"", 1'b0);             // quote mark, six symbols
    send_byte(",", 1'b0);
    send_byte(CHAR_SPACE, 1'b0);       // word gap
    send_byte(8'h7B, 1'b0);            // just past 'z', unknown
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);            // end of text means nothing here
  endtask

  // morse to text: closing, space runs, spoiled code, flush at end of text
  task automatic test_decode_directed();
    set_direction(DIR_DECODE);
    send_text("- ", 1'b0);             // T, arms the word gap
    send_byte(CHAR_SPACE, 1'b0);       // second space gives one space out
    send_byte("x", 1'b0);              // stray byte spoils the code
    send_byte(CHAR_DOT, 1'b1);         // flush of a spoiled code stays silent
    send_text("--..--", 1'b1);         // comma flushed by end of text
  endtask

  // a pending code survives a trip through encode mode
  task automatic test_direction_hold();
    send_byte(CHAR_DOT, 1'b0);
    set_direction(DIR_ENCODE);
    send_byte("E", 1'b0);
    set_direction(DIR_DECODE);
    wait_idle();
    apb_write(ADDR_UNUSED, 32'h0000_0000);   // must not touch direction
    apb_check_direction();
    send_byte(CHAR_DASH, 1'b1);              // .- closes as A
  endtask

  task automatic send_random_text();
    logic [7:0] c;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      c = morse_char[$urandom_range(0, MORSE_COUNT - 1)];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + CASE_FOLD;
    end else if (r < 65) begin
      c = CHAR_SPACE;
    end else begin
      c = $urandom_range(0, 255);
    end
    send_byte(c, $urandom_range(0, 1));
  endtask

  // a few codes with space runs between them, maybe closed by end of text
  task automatic send_random_morse();
    logic [7:0] word [$];
    string      sym;
    int         r;
    int         n;
    for (int c = 0; c < $urandom_range(1, 4); c++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        sym = morse_code[$urandom_range(0, MORSE_COUNT - 1)];
        for (int k = 0; k < sym.len(); k++) word.push_back(sym[k]);
      end else begin
        n = $urandom_range(1, 7);
        for (int k = 0; k < n; k++)
          word.push_back($urandom_range(0, 1) ? CHAR_DASH : CHAR_DOT);
        if (r >= 90) word[$urandom_range(0, n - 1)] = $urandom_range(0, 255);
      end
      for (int k = 0; k < $urandom_range(1, 3); k++) word.push_back(CHAR_SPACE);
    end
    if ($urandom_range(0, 9) < 3) void'(word.pop_back());
    r = $urandom_range(0, 99);
    foreach (word[k])
      send_byte(word[k], (r < 35) && (k == word.size() - 1));
  endtask

  // alternating phases; two phases run with no idling on either side
  task automatic test_random_traffic();
    int start_count;
    int phase_start;
    int phase;
    start_count = items_sent;
    phase = 0;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      set_direction(phase % 2 == 0 ? DIR_DECODE : DIR_ENCODE);
      no_idle = (phase == 2 || phase == 3);
      phase_start = items_sent;
      while (items_sent - phase_start < 35) begin
        if (dir_model == DIR_ENCODE) send_random_text();
        else if ($urandom_range(0, 9) == 0) send_byte($urandom_range(0, 255),
                                                      $urandom_range(0, 1));
        else send_random_morse();
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  // ------------------------------------------------------------- checking

  // every accepted result byte against the oldest owed byte
  always @(posedge clk) begin : check_results
    morse_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: out_char %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_bytes.pop_front();
        if (want.ch !== m_axis_tdata || want.last !== m_axis_tlast) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: expected out_char %h last %b, got %h last %b",
                     want.ch, want.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // result side back-pressure, stalls of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!no_idle) stall_left <= pick_gap();
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    stall_left     = 0;
    no_idle        = 1'b0;
    cycle_count    = 0;
    items_sent     = 0;
    encode_items   = 0;
    decode_items   = 0;
    bytes_checked  = 0;
    mismatch_count = 0;
    dir_model      = DIR_ENCODE;
    dec_bits       = '0;
    dec_len        = '0;
    dec_spoiled    = 1'b0;
    space_armed    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_encode_directed();
    test_decode_directed();
    test_direction_hold();
    test_random_traffic();
    wait_idle();

    $display("%0d requests (%0d text, %0d morse), %0d result bytes checked",
             items_sent, encode_items, decode_items, bytes_checked);
    $display("direction switched across phases, gaps and stalls on both streams");
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d result bytes never arrived",
               mismatch_count, pending_bytes.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
